/* hdl/fcte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcte_pkg
// Shared types and constants of the chain table engine: command and status
// codes, table entry codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package fcte_pkg;

   // default table depth
   localparam int NUM_BLOCKS_DEF = 1024;

   // field widths
   localparam int BLK_W   = 10;
   localparam int ENTRY_W = 11;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = 11;

   // reset value of the first data block register
   localparam logic [BLK_W-1:0] FIRST_DATA_BLOCK_RST = 10'd5;

   // table entry codes
   localparam logic [ENTRY_W-1:0] ENTRY_FREE = 11'h000;
   localparam logic [ENTRY_W-1:0] ENTRY_END  = 11'h7FE;
   localparam logic [ENTRY_W-1:0] ENTRY_RSVD = 11'h7FF;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LINK       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MARK_END   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FREE_CHAIN = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_FREE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NO_SUCC = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_ALLOC,
      ST_FREE
   } state_type;

endpackage

/* hdl/fat_chain_table_engine_core.sv */
`timescale 1ns / 1ps
// In idle a command is taken and its entry (for allocate, the entry at the
// free cursor) is read into a register; link, mark end, lookup and unused codes
// then register their result; allocate first scans forward past non-free entries,
// free chain first walks and clears the chain; a result stall holds the sequencer.
// One command at a time. Reset (synchronous): a clearing pass zeroes all
// NUM_BLOCKS entries with req_stall high; csr writes are taken during the pass.
// ----------------------------------------------------------------------------
// fat_chain_table_engine_core
// Block allocation table with chain link, mark, lookup, forward-only free
// scan and chain free walk, sequenced over a single table memory.
// ----------------------------------------------------------------------------
module fat_chain_table_engine_core
   import fcte_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_wr_en,
   input  logic [BLK_W-1:0]  csr_wr_data,
   // command channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [BLK_W-1:0]  req_block_index,
   input  logic [BLK_W-1:0]  req_next_index,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BLK_W-1:0]  rsp_result_block,
   output logic [STAT_W-1:0] rsp_status,
   output logic [CNT_W-1:0]  rsp_freed_count
);

   localparam int AW    = $clog2(NUM_BLOCKS);
   localparam int CUR_N = $clog2(NUM_BLOCKS + 1);
   localparam int CW    = (CUR_N > BLK_W) ? CUR_N : BLK_W;

   // table memory
   logic [ENTRY_W-1:0] table_mem [NUM_BLOCKS];
   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic [ENTRY_W-1:0] mem_wd;
   logic               mem_re;
   logic [AW-1:0]      mem_ra;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               byp_ff, byp_in;

   // sequencer and datapath registers
   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [BLK_W-1:0]   blk_ff, blk_in;
   logic [BLK_W-1:0]   nxt_ff, nxt_in;
   logic [BLK_W-1:0]   cur_ff, cur_in;
   logic [CW-1:0]      cursor_ff, cursor_in;
   logic [CNT_W-1:0]   freed_ff, freed_in;

   // result registers
   logic               rsp_valid_ff;
   logic [BLK_W-1:0]   rsp_result_ff;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [CNT_W-1:0]   rsp_freed_ff;

   // step results
   logic               done;
   logic               out_free;
   logic [BLK_W-1:0]   res_block;
   logic [STAT_W-1:0]  res_status;
   logic [CNT_W-1:0]   res_freed;

   logic [ENTRY_W-1:0] entry;
   logic               entry_link;
   logic               blk_ok;
   logic               cur_ok;
   logic               cursor_ok;
   logic [BLK_W-1:0]   follow;
   logic [CW-1:0]      cursor_inc;

   // entry as seen by the sequencer; a read that hit the entry cleared in
   // the same cycle sees it free
   assign entry      = byp_ff ? ENTRY_FREE : rd_data_ff;
   assign entry_link = (entry != ENTRY_FREE) && (entry != ENTRY_END) &&
                       (entry != ENTRY_RSVD);
   assign blk_ok     = 32'(blk_ff) < 32'(NUM_BLOCKS);
   assign cur_ok     = (cur_ff != '0) && (32'(cur_ff) < 32'(NUM_BLOCKS));
   assign cursor_ok  = 32'(cursor_ff) < 32'(NUM_BLOCKS);
   assign follow     = entry_link ? BLK_W'(entry) : '0;
   assign cursor_inc = cursor_ff + 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(NUM_BLOCKS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_ALLOC)           state_in = ST_ALLOC;
               else if (req_cmd == CMD_FREE_CHAIN) state_in = ST_FREE;
               else                                state_in = ST_EXEC;
            end
         end
         ST_EXEC, ST_ALLOC, ST_FREE: begin
            if (done && out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath
   always_comb begin
      mem_we     = 1'b0;
      mem_wa     = clr_ff;
      mem_wd     = ENTRY_FREE;
      mem_re     = 1'b0;
      mem_ra     = '0;
      byp_in     = 1'b0;
      done       = 1'b0;
      res_block  = '0;
      res_status = STAT_OK;
      res_freed  = '0;
      clr_in     = clr_ff;
      cmd_in     = cmd_ff;
      blk_in     = blk_ff;
      nxt_in     = nxt_ff;
      cur_in     = cur_ff;
      cursor_in  = cursor_ff;
      freed_in   = freed_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               blk_in   = req_block_index;
               nxt_in   = req_next_index;
               cur_in   = req_block_index;
               freed_in = '0;
               mem_re   = 1'b1;
               mem_ra   = (req_cmd == CMD_ALLOC) ? AW'(cursor_ff) : AW'(req_block_index);
            end
         end
         ST_EXEC: begin
            done = 1'b1;
            case (cmd_ff)
               CMD_LINK: begin
                  mem_we = blk_ok;
                  mem_wa = AW'(blk_ff);
                  mem_wd = ENTRY_W'(nxt_ff);
               end
               CMD_MARK_END: begin
                  mem_we = blk_ok;
                  mem_wa = AW'(blk_ff);
                  mem_wd = ENTRY_END;
               end
               CMD_LOOKUP: begin
                  if (blk_ok && entry_link) res_block = BLK_W'(entry);
                  else                      res_status = STAT_NO_SUCC;
               end
               default: ;
            endcase
         end
         ST_ALLOC: begin
            if (!cursor_ok) begin
               // table exhausted: cursor parks at the end
               done       = 1'b1;
               res_status = STAT_NO_FREE;
               cursor_in  = CW'(NUM_BLOCKS);
            end else if (entry == ENTRY_FREE) begin
               done      = 1'b1;
               res_block = BLK_W'(cursor_ff);
            end else begin
               cursor_in = cursor_inc;
               mem_re    = 1'b1;
               mem_ra    = AW'(cursor_inc);
            end
         end
         ST_FREE: begin
            if (!cur_ok) begin
               done      = 1'b1;
               res_freed = freed_ff;
            end else begin
               // clear this entry and fetch its successor
               mem_we = 1'b1;
               mem_wa = AW'(cur_ff);
               mem_wd = ENTRY_FREE;
               if (entry != ENTRY_FREE) freed_in = freed_ff + 1'b1;
               cur_in = follow;
               mem_re = 1'b1;
               mem_ra = AW'(follow);
               byp_in = (follow == cur_ff);
            end
         end
         default: ;
      endcase
      // register write reloads the free cursor
      if (csr_wr_en) cursor_in = CW'(csr_wr_data);
   end

   // table memory ports
   always_ff @(posedge clock) begin
      if (mem_we) table_mem[mem_wa] <= mem_wd;
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= table_mem[mem_ra];
         byp_ff     <= byp_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         cursor_ff <= CW'(FIRST_DATA_BLOCK_RST);
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         cursor_ff <= cursor_in;
      end
   end

   // command payload registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      blk_ff   <= blk_in;
      nxt_ff   <= nxt_in;
      cur_ff   <= cur_in;
      freed_ff <= freed_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done && out_free) begin
         rsp_result_ff <= res_block;
         rsp_status_ff <= res_status;
         rsp_freed_ff  <= res_freed;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = rsp_result_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_freed_count  = rsp_freed_ff;

   // no free block always comes with block zero
   a_nofree_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_NO_FREE) |-> (rsp_result_block == '0))
      else $error("no-free status with nonzero block");

   // a freed count only comes from a free chain result
   a_freed_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_freed_count != '0) |->
         (rsp_status == STAT_OK && rsp_result_block == '0))
      else $error("freed count on a non-free result");

   // the free cursor only moves forward between register writes
   a_cursor_fwd: assert property (@(posedge clock) disable iff (reset)
      (!csr_wr_en) |=> (cursor_ff >= $past(cursor_ff)))
      else $error("free cursor moved backward");

   // the chain walk clears at most one entry per cycle
   a_walk_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FREE) |=> (CNT_W'(freed_ff - $past(freed_ff)) <= CNT_W'(1)))
      else $error("freed count jumped");

endmodule
